// ----- hw/rtl/tci_pkg.sv -----
// ----------------------------------------------------------------------------
// tci_pkg
// Shared constants of the triangle incenter block.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DIST_W         = 25;
    localparam int CTR_W          = 24;

endpackage

// ----- hw/rtl/tci_if.sv -----
// ----------------------------------------------------------------------------
// tci_if
// Valid/ready channels of the triangle incenter block: vertices in, result out.
// ----------------------------------------------------------------------------
interface tci_in_if #(
    parameter int CW = tci_pkg::COORD_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
    logic signed [CW-1:0] p3_x;
    logic signed [CW-1:0] p3_y;

    modport source (output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, input ready);
    modport sink   (input valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, output ready);
endinterface

interface tci_out_if ();
    logic                              valid;
    logic                              ready;
    logic        [tci_pkg::DIST_W-1:0] dist_12;
    logic        [tci_pkg::DIST_W-1:0] dist_23;
    logic        [tci_pkg::DIST_W-1:0] dist_31;
    logic signed [tci_pkg::CTR_W-1:0]  incenter_x;
    logic signed [tci_pkg::CTR_W-1:0]  incenter_y;
    logic                              degenerate;

    modport source (output valid, dist_12, dist_23, dist_31, incenter_x, incenter_y,
                    degenerate, input ready);
    modport sink   (input valid, dist_12, dist_23, dist_31, incenter_x, incenter_y,
                    degenerate, output ready);
endinterface

// ----- hw/rtl/tci_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// tci_sqrt_pipe
// Pipelined floor square root, one root bit per stage, several lanes in
// parallel with a common sideband word.
// ----------------------------------------------------------------------------
module tci_sqrt_pipe #(
    parameter int RAD_W  = 49,
    parameter int LANES  = 3,
    parameter int SB_W   = 1,
    parameter int ROOT_W = (RAD_W + 1) / 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [LANES-1:0][RAD_W-1:0]       i_rad,
    input  logic [SB_W-1:0]                   i_sb,
    output logic                              o_valid,
    output logic [LANES-1:0][ROOT_W-1:0]      o_root,
    output logic [SB_W-1:0]                   o_sb
);

    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int T_W   = REM_W + 2;

    logic [ROOT_W-1:0]                r_vld;
    logic [LANES-1:0][PAD_W-1:0]      r_rad  [ROOT_W];
    logic [LANES-1:0][REM_W-1:0]      r_rem  [ROOT_W];
    logic [LANES-1:0][ROOT_W-1:0]     r_root [ROOT_W];
    logic [SB_W-1:0]                  r_sb   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic                         a_vld;
        logic [SB_W-1:0]              a_sb;
        logic [LANES-1:0][PAD_W-1:0]  a_rad;
        logic [LANES-1:0][REM_W-1:0]  a_rem;
        logic [LANES-1:0][ROOT_W-1:0] a_root;
        logic [LANES-1:0][PAD_W-1:0]  n_rad;
        logic [LANES-1:0][REM_W-1:0]  n_rem;
        logic [LANES-1:0][ROOT_W-1:0] n_root;

        if (k == 0) begin : g_src
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    a_rad[l]  = PAD_W'(i_rad[l]);
                    a_rem[l]  = '0;
                    a_root[l] = '0;
                end
            end
            assign a_vld = i_valid;
            assign a_sb  = i_sb;
        end else begin : g_chain
            assign a_rad  = r_rad[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_vld  = r_vld[k-1];
            assign a_sb   = r_sb[k-1];
        end

        always_comb begin
            logic [T_W-1:0] t;
            logic [T_W-1:0] d;
            for (int l = 0; l < LANES; l++) begin
                t = T_W'({a_rem[l], a_rad[l][PAD_W-1 -: 2]});
                d = T_W'({a_root[l], 2'b01});
                if (t >= d) begin
                    n_rem[l]  = REM_W'(t - d);
                    n_root[l] = {a_root[l][ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem[l]  = REM_W'(t);
                    n_root[l] = {a_root[l][ROOT_W-2:0], 1'b0};
                end
                n_rad[l] = a_rad[l] << 2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= n_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_sb[k]   <= a_sb;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_sb    = r_sb[ROOT_W-1];

endmodule

// ----- hw/rtl/tci_div_pipe.sv -----
// ----------------------------------------------------------------------------
// tci_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several dividends
// over one shared divisor, with a common sideband word.
// ----------------------------------------------------------------------------
module tci_div_pipe #(
    parameter int DVD_W = 51,
    parameter int DIV_W = 27,
    parameter int QW    = 24,
    parameter int LANES = 2,
    parameter int SB_W  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][DVD_W-1:0]   i_dvd,
    input  logic [DIV_W-1:0]              i_div,
    input  logic [SB_W-1:0]               i_sb,
    output logic                          o_valid,
    output logic [LANES-1:0][QW-1:0]      o_quo,
    output logic [SB_W-1:0]               o_sb
);

    logic [QW-1:0]                 r_vld;
    logic [LANES-1:0][QW-1:0]      r_lo  [QW];
    logic [LANES-1:0][DIV_W-1:0]   r_rem [QW];
    logic [DIV_W-1:0]              r_div [QW];
    logic [SB_W-1:0]               r_sb  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                        a_vld;
        logic [SB_W-1:0]             a_sb;
        logic [DIV_W-1:0]            a_div;
        logic [LANES-1:0][QW-1:0]    a_lo;
        logic [LANES-1:0][DIV_W-1:0] a_rem;
        logic [LANES-1:0][QW-1:0]    n_lo;
        logic [LANES-1:0][DIV_W-1:0] n_rem;

        if (k == 0) begin : g_src
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    a_lo[l]  = i_dvd[l][QW-1:0];
                    a_rem[l] = DIV_W'(i_dvd[l] >> QW);
                end
            end
            assign a_vld = i_valid;
            assign a_sb  = i_sb;
            assign a_div = i_div;
        end else begin : g_chain
            assign a_lo  = r_lo[k-1];
            assign a_rem = r_rem[k-1];
            assign a_vld = r_vld[k-1];
            assign a_sb  = r_sb[k-1];
            assign a_div = r_div[k-1];
        end

        always_comb begin
            logic [DIV_W:0] t;
            for (int l = 0; l < LANES; l++) begin
                t = {a_rem[l], a_lo[l][QW-1]};
                if (t >= {1'b0, a_div}) begin
                    n_rem[l] = DIV_W'(t - {1'b0, a_div});
                    n_lo[l]  = {a_lo[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = DIV_W'(t);
                    n_lo[l]  = {a_lo[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[k]  <= n_lo;
                r_rem[k] <= n_rem;
                r_div[k] <= a_div;
                r_sb[k]  <= a_sb;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_lo[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

// ----- hw/rtl/triangle_incenter.sv -----
// ----------------------------------------------------------------------------
// triangle_incenter
// Side lengths and incenter of a triangle given by three integer vertices.
// ----------------------------------------------------------------------------
// Stages: 3 front stages, one per root bit, 2 weighting stages, one per quotient
//   bit, output stage.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits on the output.
// Reset: clears the valid bits of every stage; data registers are not reset.
module triangle_incenter #(
    parameter int COORD_BITS = tci_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tci_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tci_in_if.sink     i_in,
    tci_out_if.source  o_out
);

    localparam int CW     = COORD_BITS;
    localparam int SQ_W   = 2 * CW;
    localparam int RAD_W  = SQ_W + 1 + 2 * FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PER_W  = ROOT_W + 2;
    localparam int PROD_W = ROOT_W + 1 + CW;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DVD_W  = NUM_W + FRAC_BITS;
    localparam int QW     = CW + FRAC_BITS;
    localparam int SB1_W  = 6 * CW;
    localparam int SB2_W  = 3 * ROOT_W + 3;
    localparam int DIST_W = tci_pkg::DIST_W;
    localparam int CTR_W  = tci_pkg::CTR_W;

    function automatic logic [CW-1:0] f_absdiff(logic [CW-1:0] a, logic [CW-1:0] b);
        logic signed [CW:0] d;
        d = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
        return d[CW] ? CW'(-d) : CW'(d);
    endfunction

    logic en;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // front end: differences, squares, radicands
    logic                       r_a_vld, r_b_vld, r_c_vld;
    logic [5:0][CW-1:0]         n_a_pt, r_a_pt, r_b_pt, r_c_pt;
    logic [5:0][CW-1:0]         n_a_dd, r_a_dd;
    logic [5:0][SQ_W-1:0]       r_b_sq;
    logic [2:0][RAD_W-1:0]      r_c_rad;

    assign n_a_pt = {i_in.p3_y, i_in.p3_x, i_in.p2_y, i_in.p2_x, i_in.p1_y, i_in.p1_x};

    always_comb begin
        for (int s = 0; s < 3; s++) begin
            n_a_dd[2*s]   = f_absdiff(n_a_pt[2*s],   n_a_pt[(2*s+2)%6]);
            n_a_dd[2*s+1] = f_absdiff(n_a_pt[2*s+1], n_a_pt[(2*s+3)%6]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_pt <= n_a_pt;
            r_a_dd <= n_a_dd;
            r_b_pt <= r_a_pt;
            r_c_pt <= r_b_pt;
            for (int j = 0; j < 6; j++) begin
                r_b_sq[j] <= SQ_W'(r_a_dd[j]) * SQ_W'(r_a_dd[j]);
            end
            for (int s = 0; s < 3; s++) begin
                r_c_rad[s] <= RAD_W'({1'b0, r_b_sq[2*s]} + {1'b0, r_b_sq[2*s+1]})
                              << (2 * FRAC_BITS);
            end
        end
    end

    // side lengths
    logic                       sq_vld;
    logic [2:0][ROOT_W-1:0]     sq_d;
    logic [SB1_W-1:0]           sq_sb;
    logic [5:0][CW-1:0]         sq_pt;

    tci_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .LANES  (3),
        .SB_W   (SB1_W),
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_rad   (r_c_rad),
        .i_sb    (r_c_pt),
        .o_valid (sq_vld),
        .o_root  (sq_d),
        .o_sb    (sq_sb)
    );

    assign sq_pt = sq_sb;

    // weighted sums and perimeter
    logic                             r_d_vld, r_e_vld;
    logic [1:0][2:0][PROD_W-1:0]      r_d_prod;
    logic [PER_W-1:0]                 r_d_per, r_e_per;
    logic [2:0][ROOT_W-1:0]           r_d_d, r_e_d;
    logic [1:0][DVD_W-1:0]            r_e_dvd;
    logic [1:0]                       r_e_neg;
    logic                             r_e_deg;
    logic [1:0][DVD_W-1:0]            n_e_dvd;
    logic [1:0]                       n_e_neg;

    always_comb begin
        logic signed [NUM_W-1:0] num;
        logic        [NUM_W-1:0] mg;
        for (int c = 0; c < 2; c++) begin
            num = NUM_W'($signed(r_d_prod[c][0])) + NUM_W'($signed(r_d_prod[c][1]))
                + NUM_W'($signed(r_d_prod[c][2]));
            n_e_neg[c] = num[NUM_W-1];
            mg         = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            n_e_dvd[c] = DVD_W'(mg) << FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= sq_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                for (int v = 0; v < 3; v++) begin
                    r_d_prod[c][v] <= PROD_W'($signed({1'b0, sq_d[(v+1)%3]}))
                                    * PROD_W'($signed(sq_pt[2*v+c]));
                end
            end
            r_d_per <= PER_W'(sq_d[0]) + PER_W'(sq_d[1]) + PER_W'(sq_d[2]);
            r_d_d   <= sq_d;
            r_e_dvd <= n_e_dvd;
            r_e_neg <= n_e_neg;
            r_e_per <= r_d_per;
            r_e_deg <= (r_d_per == '0);
            r_e_d   <= r_d_d;
        end
    end

    // division by the perimeter
    logic                       dv_vld;
    logic [1:0][QW-1:0]         dv_q;
    logic [SB2_W-1:0]           dv_sb;
    logic [2:0][ROOT_W-1:0]     dv_d;
    logic [1:0]                 dv_neg;
    logic                       dv_deg;

    tci_div_pipe #(
        .DVD_W (DVD_W),
        .DIV_W (PER_W),
        .QW    (QW),
        .LANES (2),
        .SB_W  (SB2_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_vld),
        .i_dvd   (r_e_dvd),
        .i_div   (r_e_per),
        .i_sb    ({r_e_deg, r_e_neg, r_e_d}),
        .o_valid (dv_vld),
        .o_quo   (dv_q),
        .o_sb    (dv_sb)
    );

    assign {dv_deg, dv_neg, dv_d} = dv_sb;

    // output register
    logic                          r_f_vld;
    logic [2:0][DIST_W-1:0]        r_f_dist;
    logic [1:0][CTR_W-1:0]         r_f_ctr;
    logic                          r_f_deg;
    logic [1:0][CTR_W-1:0]         n_f_ctr;

    always_comb begin
        logic signed [QW:0] sq;
        for (int c = 0; c < 2; c++) begin
            sq = dv_neg[c] ? -$signed({1'b0, dv_q[c]}) : $signed({1'b0, dv_q[c]});
            n_f_ctr[c] = dv_deg ? '0 : CTR_W'(sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < 3; s++) begin
                r_f_dist[s] <= DIST_W'(dv_d[s]);
            end
            r_f_ctr <= n_f_ctr;
            r_f_deg <= dv_deg;
        end
    end

    assign o_out.valid      = r_f_vld;
    assign o_out.dist_12    = r_f_dist[0];
    assign o_out.dist_23    = r_f_dist[1];
    assign o_out.dist_31    = r_f_dist[2];
    assign o_out.incenter_x = r_f_ctr[0];
    assign o_out.incenter_y = r_f_ctr[1];
    assign o_out.degenerate = r_f_deg;

`ifndef NO_ASSERTIONS
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld && r_f_deg |-> r_f_dist[0] == '0 && r_f_dist[1] == '0
                               && r_f_dist[2] == '0 && r_f_ctr[0] == '0 && r_f_ctr[1] == '0)
        else $error("degenerate result with nonzero field");

    a_nondeg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld && !r_f_deg |-> r_f_dist[0] != '0 || r_f_dist[1] != '0 || r_f_dist[2] != '0)
        else $error("zero perimeter not flagged");

    a_tri_ineq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld |-> {2'b00, r_f_dist[0]} <= {2'b00, r_f_dist[1]} + {2'b00, r_f_dist[2]} + 1'b1)
        else $error("side lengths break triangle inequality");
`endif

endmodule

// ----- sim/triangle_incenter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_incenter_tb
// Sends triangles to the incenter block and compares every result with a
// predicted one: side lengths by integer root, incenter by weighted average.
// ----------------------------------------------------------------------------
module triangle_incenter_tb;

    localparam int CW = tci_pkg::COORD_BITS_DEF;
    localparam int FB = tci_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [CW-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    } t_tri;

    typedef struct packed {
        logic [tci_pkg::DIST_W-1:0]       d12, d23, d31;
        logic signed [tci_pkg::CTR_W-1:0] cx, cy;
        logic                             degen;
    } t_incenter;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tci_in_if  #(.CW(CW)) vtx_ch ();
    tci_out_if            res_ch ();

    triangle_incenter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vtx_ch.sink),
        .o_out   (res_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_incenter expected_q[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_degen = 0;
    bit        hold_off = 1'b0;

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned side_length(longint ax, longint ay,
                                                    longint bx, longint by);
        longint dx;
        longint dy;
        dx = bx - ax;
        dy = by - ay;
        return root_floor(longint'(dx * dx + dy * dy) << (2 * FB));
    endfunction

    function automatic logic [tci_pkg::CTR_W-1:0] weighted_coord(
        longint v1, longint v2, longint v3, longint d12, longint d23, longint d31);
        longint          num;
        longint unsigned q;
        num = d23 * v1 + d31 * v2 + d12 * v3;
        q = ((num < 0 ? -num : num) << FB) / longint'(d12 + d23 + d31);
        if (num < 0) q = -q;
        return q[tci_pkg::CTR_W-1:0];
    endfunction

    function automatic t_incenter predict_incenter(t_tri t);
        t_incenter       r;
        longint unsigned a, b, c;
        a = side_length(t.p1_x, t.p1_y, t.p2_x, t.p2_y);
        b = side_length(t.p2_x, t.p2_y, t.p3_x, t.p3_y);
        c = side_length(t.p3_x, t.p3_y, t.p1_x, t.p1_y);
        r.d12 = a[tci_pkg::DIST_W-1:0];
        r.d23 = b[tci_pkg::DIST_W-1:0];
        r.d31 = c[tci_pkg::DIST_W-1:0];
        r.degen = (a + b + c == 0);
        if (r.degen) begin
            r.cx = '0;
            r.cy = '0;
        end else begin
            r.cx = weighted_coord(t.p1_x, t.p2_x, t.p3_x, a, b, c);
            r.cy = weighted_coord(t.p1_y, t.p2_y, t.p3_y, a, b, c);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_triangle(t_tri t);
        int g;
        g = gap_len();
        if (g > 0) begin
            vtx_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        expected_q.push_back(predict_incenter(t));
        vtx_ch.valid <= 1'b1;
        {vtx_ch.p1_x, vtx_ch.p1_y, vtx_ch.p2_x, vtx_ch.p2_y, vtx_ch.p3_x, vtx_ch.p3_y} <= t;
        do @(posedge i_clk); while (!vtx_ch.ready);
    endtask

    // ready side: random gaps, or a long hold-off when requested
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) res_ch.ready <= 1'b0;
            else res_ch.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_incenter want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = expected_q.pop_front();
                if (res_ch.dist_12 !== want.d12)
                    report_mismatch("dist_12", res_ch.dist_12, want.d12);
                if (res_ch.dist_23 !== want.d23)
                    report_mismatch("dist_23", res_ch.dist_23, want.d23);
                if (res_ch.dist_31 !== want.d31)
                    report_mismatch("dist_31", res_ch.dist_31, want.d31);
                if (res_ch.incenter_x !== want.cx)
                    report_mismatch("incenter_x", res_ch.incenter_x, want.cx);
                if (res_ch.incenter_y !== want.cy)
                    report_mismatch("incenter_y", res_ch.incenter_y, want.cy);
                if (res_ch.degenerate !== want.degen)
                    report_mismatch("degenerate", res_ch.degenerate, want.degen);
                if (want.degen) n_degen++;
            end
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return CW'($urandom_range(0, 15)) - CW'(8);
            default: return CW'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        logic [CW-1:0] lo, hi;
        lo = 16'h8000;
        hi = 16'h7fff;
        send_triangle('0);
        send_triangle({hi, hi, hi, hi, hi, hi});
        send_triangle({lo, lo, lo, lo, lo, lo});
        send_triangle({lo, lo, hi, hi, lo, hi});
        send_triangle({hi, lo, lo, hi, hi, hi});
        send_triangle({lo, lo, hi, hi, lo, lo});
        send_triangle({16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd0, 16'sd3});
        send_triangle({16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd2});
        send_triangle({-16'sd5, 16'sd7, 16'sd3, -16'sd2, -16'sd5, 16'sd7});
        send_triangle({16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1});
        send_triangle({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
        send_triangle({16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h0f0f, 16'hf0f0});
    endtask

    task automatic test_random(int n);
        t_tri t;
        repeat (n) begin
            t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord()};
            if ($urandom_range(0, 19) == 0) begin
                t.p2_x = t.p1_x; t.p2_y = t.p1_y; t.p3_x = t.p1_x; t.p3_y = t.p1_y;
            end
            send_triangle(t);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(120);
        join
    endtask

    initial begin
        vtx_ch.valid = 1'b0;
        {vtx_ch.p1_x, vtx_ch.p1_y, vtx_ch.p2_x, vtx_ch.p2_y, vtx_ch.p3_x, vtx_ch.p3_y} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(720);
        vtx_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("covered %0d triangles, %0d degenerate, incl. extremes and a long stall",
                 n_results, n_degen);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
